// ===== rtl/core/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
// No dependencies.
`default_nettype none
package scc_pkg;
  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 4096;
  localparam int NodeW = 11;
  localparam int EdgeAw = 12;
  localparam int EdgeCntW = 13;
  localparam int NodeAw = 10;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_COMP  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_P1_START,
    S_ROOT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_VIS_CHK,
    S_POP,
    S_P2_CLR,
    S_P2_NEXT,
    S_P2_RD,
    S_QUERY
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/strongly_connected_components.sv =====
// Kosaraju strongly connected components over an on-chip edge store.
// Depends on scc_pkg.
//
// Channels: in_valid/in_ready takes one command (mode, from_node, to_node);
// out_valid/out_ready returns value and status for compute and query.
// node_count is set through cfg_we/cfg_wdata; the user must write it only
// while the block is idle: the block does not enforce this. Add edge and
// clear give no result. A query of a node out of range, or before any
// compute, shows its result the cycle after the transfer; any other query
// is answered after a label read in S_QUERY. A compute first sweeps the
// visited marks and labels, runs the forward pass, sweeps the visited
// marks again and runs the reverse pass. Every node scans the whole edge
// store once per pass; the block takes no command meanwhile.
// The edge store has one write and one read port; the visited marks, the
// stacks and the label memory are single-port synchronous RAMs, all with
// registered reads.
// Reset (synchronous, rst_n low) empties the edge store, clears the dropped
// flag and sets node_count to 1; labels read as 0 until the first compute
// (a label valid flag covers this). A result waits in the output register
// while out_ready is low; a new command is taken only once it is transferred.
`default_nettype none
module strongly_connected_components (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [10:0] in_from_node,
  input  wire logic [10:0] in_to_node,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);
  localparam int NW = scc_pkg::NodeW;
  localparam int AW = scc_pkg::NodeAw;
  localparam int EA = scc_pkg::EdgeAw;
  localparam int EC = scc_pkg::EdgeCntW;

  // memories
  logic [NW-1:0] src_mem [scc_pkg::MaxEdges];
  logic [NW-1:0] dst_mem [scc_pkg::MaxEdges];
  logic          vis_mem [scc_pkg::MaxNodes];
  logic [NW-1:0] fin_mem [scc_pkg::MaxNodes];
  logic [NW-1:0] wsn_mem [scc_pkg::MaxNodes];
  logic [EC-1:0] wsp_mem [scc_pkg::MaxNodes];
  logic [NW-1:0] lab_mem [scc_pkg::MaxNodes];

  scc_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] ncfg_r;
  logic [NW-1:0] n;
  logic [EC-1:0] ecnt_r, ecnt_nxt;
  logic          drop_r, drop_nxt;
  logic          labv_r, labv_nxt;
  logic          fwd_r, fwd_nxt;
  logic [NW-1:0] iter_r, iter_nxt;      // outer node loop / clear sweep
  logic [NW-1:0] fdep_r, fdep_nxt;      // finish stack depth
  logic [NW-1:0] wdep_r, wdep_nxt;      // walk stack depth
  logic [NW-1:0] u_r, u_nxt;            // node on top of walk stack
  logic [EC-1:0] e_r, e_nxt;            // scan position
  logic [NW-1:0] lab_r, lab_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic          ov_r, ov_nxt;
  logic [NW-1:0] oval_r, oval_nxt;
  logic [1:0]    ost_r, ost_nxt;

  // memory ports
  logic          e_we; logic [EA-1:0] e_wa; logic [NW-1:0] e_ws, e_wd;
  logic [EA-1:0] e_ra; logic [NW-1:0] e_rs, e_rd;
  logic          v_we, v_wd; logic [AW-1:0] v_a; logic v_rd;
  logic          f_we; logic [AW-1:0] f_a; logic [NW-1:0] f_wd, f_rd;
  logic          w_we; logic [AW-1:0] w_a; logic [NW-1:0] w_wn, w_rn;
  logic [EC-1:0] w_wp, w_rp;
  logic          l_we; logic [AW-1:0] l_a; logic [NW-1:0] l_wd, l_rd;

  always_ff @(posedge clk) begin
    if (e_we) begin
      src_mem[e_wa] <= e_ws;
      dst_mem[e_wa] <= e_wd;
    end
    e_rs <= src_mem[e_ra];
    e_rd <= dst_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) vis_mem[v_a] <= v_wd;
    v_rd <= vis_mem[v_a];
  end

  always_ff @(posedge clk) begin
    if (f_we) fin_mem[f_a] <= f_wd;
    f_rd <= fin_mem[f_a];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wsn_mem[w_a] <= w_wn;
      wsp_mem[w_a] <= w_wp;
    end
    w_rn <= wsn_mem[w_a];
    w_rp <= wsp_mem[w_a];
  end

  always_ff @(posedge clk) begin
    if (l_we) lab_mem[l_a] <= l_wd;
    l_rd <= lab_mem[l_a];
  end

  // clamp node count
  always_comb begin
    if (ncfg_r == '0) n = NW'(1);
    else if (ncfg_r > NW'(scc_pkg::MaxNodes)) n = NW'(scc_pkg::MaxNodes);
    else n = ncfg_r;
  end

  // edge under scan, seen in the current direction
  logic [NW-1:0] ea, eb;
  assign ea = fwd_r ? e_rs : e_rd;
  assign eb = fwd_r ? e_rd : e_rs;

  // start node of a walk: loop node in pass one, finish stack entry in pass two
  logic [NW-1:0] root;
  assign root = fwd_r ? iter_r : b_r;

  assign in_ready  = (state_r == scc_pkg::S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_status = ost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::S_IDLE;
      ncfg_r  <= NW'(1);
      ecnt_r  <= '0;
      drop_r  <= 1'b0;
      labv_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) ncfg_r <= cfg_wdata;
      ecnt_r  <= ecnt_nxt;
      drop_r  <= drop_nxt;
      labv_r  <= labv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt; iter_r <= iter_nxt; fdep_r <= fdep_nxt; wdep_r <= wdep_nxt;
    u_r <= u_nxt; e_r <= e_nxt; lab_r <= lab_nxt; b_r <= b_nxt;
    oval_r <= oval_nxt; ost_r <= ost_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ecnt_nxt = ecnt_r; drop_nxt = drop_r; labv_nxt = labv_r;
    fwd_nxt = fwd_r; iter_nxt = iter_r; fdep_nxt = fdep_r; wdep_nxt = wdep_r;
    u_nxt = u_r; e_nxt = e_r; lab_nxt = lab_r; b_nxt = b_r;
    ov_nxt = ov_r; oval_nxt = oval_r; ost_nxt = ost_r;
    e_we = 1'b0; e_wa = ecnt_r[EA-1:0]; e_ws = in_from_node; e_wd = in_to_node;
    e_ra = e_r[EA-1:0];
    v_we = 1'b0; v_wd = 1'b0; v_a = '0;
    f_we = 1'b0; f_a = '0; f_wd = u_r;
    w_we = 1'b0; w_a = '0; w_wn = '0; w_wp = '0;
    l_we = 1'b0; l_a = '0; l_wd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      scc_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          case (scc_pkg::mode_t'(in_mode))
            scc_pkg::MODE_ADD: begin
              if (in_from_node == '0 || in_from_node > n || in_to_node == '0 ||
                  in_to_node > n || ecnt_r >= EC'(scc_pkg::MaxEdges)) begin
                drop_nxt = 1'b1;
              end else begin
                e_we = 1'b1;
                ecnt_nxt = ecnt_r + EC'(1);
              end
            end
            scc_pkg::MODE_COMP: begin
              iter_nxt = '0; fdep_nxt = '0; lab_nxt = '0; fwd_nxt = 1'b1;
              state_nxt = scc_pkg::S_CLR;
            end
            scc_pkg::MODE_QUERY: begin
              if (in_from_node == '0 || in_from_node > n) begin
                ov_nxt = 1'b1; oval_nxt = '0; ost_nxt = scc_pkg::ST_RANGE;
              end else if (!labv_r) begin
                ov_nxt = 1'b1; oval_nxt = '0; ost_nxt = scc_pkg::ST_OK;
              end else begin
                l_a = AW'(in_from_node - NW'(1));
                state_nxt = scc_pkg::S_QUERY;
              end
            end
            scc_pkg::MODE_CLEAR: begin
              ecnt_nxt = '0; drop_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // sweep visited and labels to zero
      scc_pkg::S_CLR: begin
        v_we = 1'b1; v_a = iter_r[AW-1:0];
        l_we = 1'b1; l_a = iter_r[AW-1:0];
        iter_nxt = iter_r + NW'(1);
        if (iter_r == NW'(scc_pkg::MaxNodes - 1)) begin
          labv_nxt = 1'b1;
          iter_nxt = NW'(1);
          state_nxt = scc_pkg::S_P1_START;
        end
      end
      // outer loop of pass one: read visited of iter
      scc_pkg::S_P1_START: begin
        if (iter_r > n) begin
          iter_nxt = '0;
          fwd_nxt = 1'b0;
          state_nxt = scc_pkg::S_P2_CLR;
        end else begin
          v_a = AW'(iter_r - NW'(1));
          state_nxt = scc_pkg::S_ROOT_CHK;
        end
      end
      // check start node (both passes)
      scc_pkg::S_ROOT_CHK: begin
        if (!v_rd && root != '0 && root <= n) begin
          u_nxt = root;
          v_we = 1'b1; v_wd = 1'b1; v_a = AW'(root - NW'(1));
          if (!fwd_r) begin
            l_we = 1'b1; l_a = AW'(root - NW'(1)); l_wd = lab_r + NW'(1);
            lab_nxt = lab_r + NW'(1);
          end
          wdep_nxt = NW'(1);
          e_nxt = '0;
          state_nxt = scc_pkg::S_SCAN_RD;
        end else if (fwd_r) begin
          iter_nxt = iter_r + NW'(1);
          state_nxt = scc_pkg::S_P1_START;
        end else begin
          state_nxt = scc_pkg::S_P2_NEXT;
        end
      end
      // fetch edge e, or fetch the parent frame once the scan is done
      scc_pkg::S_SCAN_RD: begin
        if (e_r >= ecnt_r) begin
          w_a = AW'(wdep_r - NW'(2));
          state_nxt = scc_pkg::S_POP;
        end else begin
          e_ra = e_r[EA-1:0];
          state_nxt = scc_pkg::S_SCAN_CHK;
        end
      end
      // edge data here; read visited of endpoint
      scc_pkg::S_SCAN_CHK: begin
        if (ea == u_r && eb != '0 && eb <= n) begin
          v_a = AW'(eb - NW'(1));
          b_nxt = eb;
          state_nxt = scc_pkg::S_VIS_CHK;
        end else begin
          e_nxt = e_r + EC'(1);
          state_nxt = scc_pkg::S_SCAN_RD;
        end
      end
      // visited of b is ready: push or continue
      scc_pkg::S_VIS_CHK: begin
        e_nxt = e_r + EC'(1);
        if (!v_rd) begin
          v_we = 1'b1; v_wd = 1'b1; v_a = AW'(b_r - NW'(1));
          if (!fwd_r) begin
            l_we = 1'b1; l_a = AW'(b_r - NW'(1)); l_wd = lab_r;
          end
          // save parent frame, descend
          w_we = 1'b1; w_a = AW'(wdep_r - NW'(1)); w_wn = u_r; w_wp = e_r + EC'(1);
          wdep_nxt = wdep_r + NW'(1);
          u_nxt = b_r;
          e_nxt = '0;
        end
        state_nxt = scc_pkg::S_SCAN_RD;
      end
      // node finished: record it (pass one only), pop parent
      scc_pkg::S_POP: begin
        if (fwd_r) begin
          f_we = 1'b1; f_a = fdep_r[AW-1:0]; f_wd = u_r;
          fdep_nxt = fdep_r + NW'(1);
        end
        wdep_nxt = wdep_r - NW'(1);
        if (wdep_r == NW'(1)) begin
          if (fwd_r) begin
            iter_nxt = iter_r + NW'(1);
            state_nxt = scc_pkg::S_P1_START;
          end else begin
            state_nxt = scc_pkg::S_P2_NEXT;
          end
        end else begin
          u_nxt = w_rn;
          e_nxt = w_rp;
          state_nxt = scc_pkg::S_SCAN_RD;
        end
      end
      // clear visited marks before pass two
      scc_pkg::S_P2_CLR: begin
        v_we = 1'b1; v_a = iter_r[AW-1:0];
        iter_nxt = iter_r + NW'(1);
        if (iter_r == NW'(scc_pkg::MaxNodes - 1)) state_nxt = scc_pkg::S_P2_NEXT;
      end
      // pop the finish stack, or hand out the count when it is empty
      scc_pkg::S_P2_NEXT: begin
        if (fdep_r == '0) begin
          ov_nxt = 1'b1; oval_nxt = lab_r;
          ost_nxt = drop_r ? scc_pkg::ST_DROPPED : scc_pkg::ST_OK;
          state_nxt = scc_pkg::S_IDLE;
        end else begin
          f_a = AW'(fdep_r - NW'(1));
          fdep_nxt = fdep_r - NW'(1);
          state_nxt = scc_pkg::S_P2_RD;
        end
      end
      // finish stack entry here; read its visited mark
      scc_pkg::S_P2_RD: begin
        b_nxt = f_rd;
        v_a = AW'(f_rd - NW'(1));
        state_nxt = scc_pkg::S_ROOT_CHK;
      end
      // label read lands: hand it out
      scc_pkg::S_QUERY: begin
        ov_nxt = 1'b1; oval_nxt = l_rd; ost_nxt = scc_pkg::ST_OK;
        state_nxt = scc_pkg::S_IDLE;
      end
      default: state_nxt = scc_pkg::S_IDLE;
    endcase
  end

  // hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status));

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid);
endmodule
`default_nettype wire
